// File: rtl/core/dmph_pkg.sv
// Package with the shared types, constants and codes of the double modulus prefix hash core.
package dmph_pkg;

  localparam int unsigned MAX_LEN_DEF = 4096;

  localparam logic [29:0] MOD_A = 30'd1000000007;
  localparam logic [29:0] MOD_B = 30'd1000000009;
  // Barrett factors floor(2^60 / M), worked out at elaboration.
  localparam logic [30:0] MU_A = 31'((64'd1 << 60) / 64'(MOD_A));
  localparam logic [30:0] MU_B = 31'((64'd1 << 60) / 64'(MOD_B));

  localparam logic [7:0] CHAR_OFFSET = 8'd96;

  localparam logic [29:0] BASE_A_RST     = 30'd47;
  localparam logic [29:0] BASE_B_RST     = 30'd31;
  localparam logic [29:0] INV_BASE_A_RST = 30'd404255322;
  localparam logic [29:0] INV_BASE_B_RST = 30'd838709685;

  localparam logic [1:0] CFG_BASE_A     = 2'd0;
  localparam logic [1:0] CFG_BASE_B     = 2'd1;
  localparam logic [1:0] CFG_INV_BASE_A = 2'd2;
  localparam logic [1:0] CFG_INV_BASE_B = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic {
    OP_APPEND,
    OP_QUERY
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AP0,
    ST_AP1,
    ST_AP2,
    ST_AWAIT,
    ST_QRD,
    ST_QSUB,
    ST_QMUL,
    ST_QWAIT
  } state_e;

  typedef struct packed {
    logic        command;
    logic        new_string;
    logic [7:0]  letter;
    logic [11:0] left;
    logic [11:0] right;
  } in_req_t;

  typedef struct packed {
    logic [29:0] hash_a;
    logic [29:0] hash_b;
    logic [1:0]  status;
  } out_req_t;

  typedef struct packed {
    op_e         op;
    logic        fresh;
    logic [7:0]  letter;
    logic [11:0] left;
    logic [11:0] right;
  } entry_t;

  typedef struct packed {
    logic [29:0] base_a;
    logic [29:0] base_b;
    logic [29:0] inv_base_a;
    logic [29:0] inv_base_b;
  } cfg_t;

endpackage

// File: rtl/core/dmph_mulmod.sv
// Four stage pipelined Barrett modular multiplier.
module dmph_mulmod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [29:0] a_i,
  input  logic [29:0] b_i,
  input  logic [29:0] m_i,
  input  logic [30:0] mu_i,
  output logic        valid_o,
  output logic [29:0] r_o
);

  logic [3:0]  v_q;
  logic [59:0] p_q;
  logic [59:0] p2_q;
  logic [61:0] q2_q;
  logic [31:0] r3_q;
  logic [29:0] r_q;
  logic [60:0] qm;
  logic [31:0] two_m;
  logic [31:0] r3_d;
  logic [29:0] r_d;

  always_comb begin
    qm    = 61'(q2_q[61:31]) * 61'(m_i);
    r3_d  = p2_q[31:0] - qm[31:0];
    two_m = 32'(m_i) << 1;
    if (r3_q >= two_m) begin
      r_d = 30'(r3_q - two_m);
    end else if (r3_q >= 32'(m_i)) begin
      r_d = 30'(r3_q - 32'(m_i));
    end else begin
      r_d = 30'(r3_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= 60'(a_i) * 60'(b_i);
    q2_q <= 62'(p_q[59:29]) * 62'(mu_i);
    p2_q <= p_q;
    r3_q <= r3_d;
    r_q  <= r_d;
  end

  assign valid_o = v_q[3];
  assign r_o     = r_q;

endmodule

// File: rtl/core/dmph_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module dmph_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dmph_pkg::in_req_t in_req_i,
  output logic              q_valid_o,
  output dmph_pkg::entry_t  q_entry_o,
  input  logic              q_pop_i
);

  dmph_pkg::entry_t fifo_q [2];
  dmph_pkg::entry_t entry;
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;

  always_comb begin
    entry.op     = (in_req_i.command == dmph_pkg::CMD_APPEND) ? dmph_pkg::OP_APPEND
                                                              : dmph_pkg::OP_QUERY;
    entry.fresh  = in_req_i.new_string;
    entry.letter = in_req_i.letter;
    entry.left   = in_req_i.left;
    entry.right  = in_req_i.right;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_entry_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// File: rtl/core/dmph_back.sv
// Back end: sequencer, prefix and inverse power memories and the result register.
module dmph_back #(
  parameter int unsigned MAX_LEN = dmph_pkg::MAX_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dmph_pkg::cfg_t     cfg_i,
  input  logic               q_valid_i,
  input  dmph_pkg::entry_t   q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dmph_pkg::out_req_t out_req_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned CW = (LW > 12) ? LW : 12;

  dmph_pkg::state_e   state_q, state_d;
  dmph_pkg::entry_t   item_q;
  dmph_pkg::out_req_t out_q;
  logic               out_valid_q;
  logic [LW-1:0]      len_q;
  logic [29:0]        pow_a_q, pow_b_q, inv_a_q, inv_b_q;
  logic [29:0]        last_a_q, last_b_q, hs_a_q, hs_b_q, d_a_q, d_b_q;
  logic [29:0]        pr_a_q, pr_b_q, pl_a_q, pl_b_q, iv_a_q, iv_b_q;
  logic [1:0]         res_cnt_q;

  logic [29:0] pre_a_mem [MAX_LEN];
  logic [29:0] pre_b_mem [MAX_LEN];
  logic [29:0] ivp_a_mem [MAX_LEN];
  logic [29:0] ivp_b_mem [MAX_LEN];

  logic        mul_v, res_v, res_v_a, res_v_b;
  logic [29:0] opa_a, opb_a, opa_b, opb_b, r_a, r_b;
  logic [29:0] lv_a, lv_b, sum_a, sum_b, diff_a, diff_b, pa, pb, pla, plb;
  logic [30:0] s31_a, s31_b, d31_a, d31_b;
  logic        bad_range, full, wr_en;

  // Both multipliers run in lockstep, so their valid flags always agree.
  assign res_v     = res_v_a && res_v_b;
  assign full      = (len_q == LW'(MAX_LEN));
  assign bad_range = (q_entry_i.left > q_entry_i.right)
                     || (CW'(q_entry_i.right) >= CW'(len_q));
  assign wr_en     = (state_q == dmph_pkg::ST_AWAIT) && res_v && (res_cnt_q == 2'd2);

  always_comb begin
    if (item_q.letter >= dmph_pkg::CHAR_OFFSET) begin
      lv_a = 30'(item_q.letter - dmph_pkg::CHAR_OFFSET);
      lv_b = lv_a;
    end else begin
      lv_a = dmph_pkg::MOD_A - 30'(dmph_pkg::CHAR_OFFSET - item_q.letter);
      lv_b = dmph_pkg::MOD_B - 30'(dmph_pkg::CHAR_OFFSET - item_q.letter);
    end
    pa    = (len_q == '0) ? 30'd0 : last_a_q;
    pb    = (len_q == '0) ? 30'd0 : last_b_q;
    s31_a = {1'b0, pa} + {1'b0, r_a};
    s31_b = {1'b0, pb} + {1'b0, r_b};
    sum_a = (s31_a >= 31'(dmph_pkg::MOD_A)) ? 30'(s31_a - 31'(dmph_pkg::MOD_A)) : 30'(s31_a);
    sum_b = (s31_b >= 31'(dmph_pkg::MOD_B)) ? 30'(s31_b - 31'(dmph_pkg::MOD_B)) : 30'(s31_b);
    pla   = (item_q.left == 12'd0) ? 30'd0 : pl_a_q;
    plb   = (item_q.left == 12'd0) ? 30'd0 : pl_b_q;
    d31_a = {1'b0, pr_a_q} + 31'(dmph_pkg::MOD_A) - {1'b0, pla};
    d31_b = {1'b0, pr_b_q} + 31'(dmph_pkg::MOD_B) - {1'b0, plb};
    diff_a = (d31_a >= 31'(dmph_pkg::MOD_A)) ? 30'(d31_a - 31'(dmph_pkg::MOD_A))
                                             : 30'(d31_a);
    diff_b = (d31_b >= 31'(dmph_pkg::MOD_B)) ? 30'(d31_b - 31'(dmph_pkg::MOD_B))
                                             : 30'(d31_b);
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    mul_v   = 1'b0;
    opa_a   = pow_a_q;
    opb_a   = lv_a;
    opa_b   = pow_b_q;
    opb_b   = lv_b;
    case (state_q)
      dmph_pkg::ST_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          if (q_entry_i.op == dmph_pkg::OP_APPEND) begin
            state_d = dmph_pkg::ST_AP0;
          end else if (!bad_range) begin
            state_d = dmph_pkg::ST_QRD;
          end
        end
      end
      dmph_pkg::ST_AP0: begin
        if (full) begin
          state_d = dmph_pkg::ST_IDLE;
        end else begin
          mul_v   = 1'b1;
          state_d = dmph_pkg::ST_AP1;
        end
      end
      dmph_pkg::ST_AP1: begin
        mul_v   = 1'b1;
        opb_a   = cfg_i.base_a;
        opb_b   = cfg_i.base_b;
        state_d = dmph_pkg::ST_AP2;
      end
      dmph_pkg::ST_AP2: begin
        mul_v   = 1'b1;
        opa_a   = inv_a_q;
        opb_a   = cfg_i.inv_base_a;
        opa_b   = inv_b_q;
        opb_b   = cfg_i.inv_base_b;
        state_d = dmph_pkg::ST_AWAIT;
      end
      dmph_pkg::ST_AWAIT: begin
        if (res_v && res_cnt_q == 2'd2) begin
          state_d = dmph_pkg::ST_IDLE;
        end
      end
      dmph_pkg::ST_QRD:  state_d = dmph_pkg::ST_QSUB;
      dmph_pkg::ST_QSUB: state_d = dmph_pkg::ST_QMUL;
      dmph_pkg::ST_QMUL: begin
        mul_v   = 1'b1;
        opa_a   = d_a_q;
        opb_a   = iv_a_q;
        opa_b   = d_b_q;
        opb_b   = iv_b_q;
        state_d = dmph_pkg::ST_QWAIT;
      end
      dmph_pkg::ST_QWAIT: begin
        if (res_v) begin
          state_d = dmph_pkg::ST_IDLE;
        end
      end
      default: state_d = dmph_pkg::ST_IDLE;
    endcase
  end

  dmph_mulmod u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_v),
    .a_i     (opa_a),
    .b_i     (opb_a),
    .m_i     (dmph_pkg::MOD_A),
    .mu_i    (dmph_pkg::MU_A),
    .valid_o (res_v_a),
    .r_o     (r_a)
  );

  dmph_mulmod u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_v),
    .a_i     (opa_b),
    .b_i     (opb_b),
    .m_i     (dmph_pkg::MOD_B),
    .mu_i    (dmph_pkg::MU_B),
    .valid_o (res_v_b),
    .r_o     (r_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmph_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: length, running powers and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pow_a_q     <= 30'd1;
      pow_b_q     <= 30'd1;
      inv_a_q     <= 30'd1;
      inv_b_q     <= 30'd1;
      res_cnt_q   <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (q_pop_o) begin
        res_cnt_q <= 2'd0;
        if (q_entry_i.op == dmph_pkg::OP_APPEND && q_entry_i.fresh) begin
          len_q   <= '0;
          pow_a_q <= 30'd1;
          pow_b_q <= 30'd1;
          inv_a_q <= 30'd1;
          inv_b_q <= 30'd1;
        end else if (q_entry_i.op == dmph_pkg::OP_QUERY && bad_range) begin
          out_valid_q <= 1'b1;
        end
      end
      if (state_q == dmph_pkg::ST_AP0 && full) begin
        out_valid_q <= 1'b1;
      end
      if (state_q == dmph_pkg::ST_AWAIT && res_v) begin
        res_cnt_q <= res_cnt_q + 2'd1;
        if (res_cnt_q == 2'd1) begin
          pow_a_q <= r_a;
          pow_b_q <= r_b;
        end
        if (res_cnt_q == 2'd2) begin
          inv_a_q     <= r_a;
          inv_b_q     <= r_b;
          len_q       <= len_q + LW'(1);
          out_valid_q <= 1'b1;
        end
      end
      if (state_q == dmph_pkg::ST_QWAIT && res_v) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_entry_i;
      out_q  <= '{hash_a: 30'd0, hash_b: 30'd0, status: dmph_pkg::STAT_RANGE};
    end
    if (state_q == dmph_pkg::ST_AP0) begin
      out_q <= '{hash_a: last_a_q, hash_b: last_b_q, status: dmph_pkg::STAT_FULL};
    end
    if (state_q == dmph_pkg::ST_AWAIT && res_v) begin
      if (res_cnt_q == 2'd0) begin
        hs_a_q <= sum_a;
        hs_b_q <= sum_b;
      end
      if (res_cnt_q == 2'd2) begin
        last_a_q <= hs_a_q;
        last_b_q <= hs_b_q;
        out_q    <= '{hash_a: hs_a_q, hash_b: hs_b_q, status: dmph_pkg::STAT_OK};
      end
    end
    if (state_q == dmph_pkg::ST_QSUB) begin
      d_a_q <= diff_a;
      d_b_q <= diff_b;
    end
    if (state_q == dmph_pkg::ST_QWAIT) begin
      out_q <= '{hash_a: r_a, hash_b: r_b, status: dmph_pkg::STAT_OK};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pre_a_mem[AW'(len_q)] <= hs_a_q;
      pre_b_mem[AW'(len_q)] <= hs_b_q;
      ivp_a_mem[AW'(len_q)] <= inv_a_q;
      ivp_b_mem[AW'(len_q)] <= inv_b_q;
    end
    if (state_q == dmph_pkg::ST_QRD) begin
      pr_a_q <= pre_a_mem[AW'(item_q.right)];
      pr_b_q <= pre_b_mem[AW'(item_q.right)];
      pl_a_q <= pre_a_mem[AW'(item_q.left - 12'd1)];
      pl_b_q <= pre_b_mem[AW'(item_q.left - 12'd1)];
      iv_a_q <= ivp_a_mem[AW'(item_q.left)];
      iv_b_q <= ivp_b_mem[AW'(item_q.left)];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// File: rtl/core/double_mod_prefix_string_hash_core.sv
// Top level of the double modulus prefix hash core.
//
//   Channel   Signals                                  Direction
//   in        in_valid_i, in_stall_o, in_req_i         request into the core
//   out       out_valid_o, out_stall_i, out_req_o      result request out of the core
//   cfg       cfg_valid_i, cfg_ready_o, cfg_index_i,   register writes
//             cfg_data_i
//
// An append request, once it leaves the queue, sends three modular products back to back into
// the four stage Barrett multiplier and shows its result when the last one lands. A query
// takes a memory read, a modular subtraction and one product. A full string is answered
// without a product, and a bad range as soon as it leaves the queue.
// The next request leaves the queue the cycle after a result is taken, so the back end never
// starts a new request while a result is still waiting on the output.
// The two entry queue keeps accepting requests, until it is full, while a result waits on a stalled output.
// Reset is asynchronous and active low; it restores the default bases and an empty string.
// The prefix memories need no clearing after reset, since only written entries are read.
module double_mod_prefix_string_hash_core #(
  parameter int unsigned MAX_LEN = dmph_pkg::MAX_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dmph_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dmph_pkg::out_req_t out_req_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [29:0]        cfg_data_i
);

  dmph_pkg::cfg_t   cfg_q;
  dmph_pkg::entry_t q_entry;
  logic             q_valid;
  logic             q_pop;

  // Writes are taken at any time; the user only writes while the core is idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_a     <= dmph_pkg::BASE_A_RST;
      cfg_q.base_b     <= dmph_pkg::BASE_B_RST;
      cfg_q.inv_base_a <= dmph_pkg::INV_BASE_A_RST;
      cfg_q.inv_base_b <= dmph_pkg::INV_BASE_B_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dmph_pkg::CFG_BASE_A:     cfg_q.base_a     <= cfg_data_i;
        dmph_pkg::CFG_BASE_B:     cfg_q.base_b     <= cfg_data_i;
        dmph_pkg::CFG_INV_BASE_A: cfg_q.inv_base_a <= cfg_data_i;
        dmph_pkg::CFG_INV_BASE_B: cfg_q.inv_base_b <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end classifies each request and holds up to two of them.
  dmph_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  // The back end works on one request at a time and owns the memories.
  dmph_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // A bad range always comes back with zero hashes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.status == dmph_pkg::STAT_RANGE)
      |-> (out_req_o.hash_a == 30'd0 && out_req_o.hash_b == 30'd0))
    else $error("bad range result carries a nonzero hash");

  // Every reported hash is reduced below its modulus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.hash_a < dmph_pkg::MOD_A
                     && out_req_o.hash_b < dmph_pkg::MOD_B))
    else $error("hash not reduced");

  // The back end only takes a request while the result register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_valid && !out_valid_o))
    else $error("queue popped while a result is pending");

endmodule

// File: sim/double_mod_prefix_string_hash_core_test.sv
// Testbench for the double modulus prefix hash core, checked against a behavioral predictor.
module double_mod_prefix_string_hash_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STR_MAX = 4096;
  localparam longint unsigned MA = 64'd1000000007;
  localparam longint unsigned MB = 64'd1000000009;
  localparam int CYCLE_LIMIT = 900000;

  // Scoreboard: a behavioral copy of the hash core plus the queue of pending results.
  class hash_scoreboard;
    logic [29:0] base_a, base_b, inv_a, inv_b;
    logic [29:0] pre_a [STR_MAX];
    logic [29:0] pre_b [STR_MAX];
    logic [29:0] ipw_a [STR_MAX];
    logic [29:0] ipw_b [STR_MAX];
    logic [29:0] pow_a, pow_b, rinv_a, rinv_b;
    int unsigned str_len;
    dmph_pkg::out_req_t pending_hashes[$];
    int errors;
    int results_seen;

    function void clear_state();
      base_a = dmph_pkg::BASE_A_RST;
      base_b = dmph_pkg::BASE_B_RST;
      inv_a = dmph_pkg::INV_BASE_A_RST;
      inv_b = dmph_pkg::INV_BASE_B_RST;
      restart_string();
    endfunction

    function void restart_string();
      pow_a = 30'd1;
      pow_b = 30'd1;
      rinv_a = 30'd1;
      rinv_b = 30'd1;
      str_len = 0;
    endfunction

    function logic [29:0] mulmod(logic [29:0] x, logic [29:0] y, longint unsigned m);
      longint unsigned prod;
      prod = longint'(x) * longint'(y);
      return 30'(prod % m);
    endfunction

    function void write_reg(logic [1:0] idx, logic [29:0] val);
      case (idx)
        dmph_pkg::CFG_BASE_A: base_a = val;
        dmph_pkg::CFG_BASE_B: base_b = val;
        dmph_pkg::CFG_INV_BASE_A: inv_a = val;
        dmph_pkg::CFG_INV_BASE_B: inv_b = val;
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted request and updates the string state.
    function void note_request(dmph_pkg::in_req_t rq);
      dmph_pkg::out_req_t r;
      longint unsigned va, vb, pa, pb, la, lb;
      r = '0;
      if (rq.command == dmph_pkg::CMD_APPEND) begin
        if (rq.new_string) restart_string();
        if (str_len >= STR_MAX) begin
          r.status = dmph_pkg::STAT_FULL;
          r.hash_a = pre_a[STR_MAX-1];
          r.hash_b = pre_b[STR_MAX-1];
        end else begin
          va = (longint'(rq.letter) + MA - 96) % MA;
          vb = (longint'(rq.letter) + MB - 96) % MB;
          pa = (str_len != 0) ? pre_a[str_len-1] : 0;
          pb = (str_len != 0) ? pre_b[str_len-1] : 0;
          r.hash_a = 30'((pa + mulmod(pow_a, 30'(va), MA)) % MA);
          r.hash_b = 30'((pb + mulmod(pow_b, 30'(vb), MB)) % MB);
          r.status = dmph_pkg::STAT_OK;
          pre_a[str_len] = r.hash_a;
          pre_b[str_len] = r.hash_b;
          ipw_a[str_len] = rinv_a;
          ipw_b[str_len] = rinv_b;
          pow_a = mulmod(pow_a, base_a, MA);
          pow_b = mulmod(pow_b, base_b, MB);
          rinv_a = mulmod(rinv_a, inv_a, MA);
          rinv_b = mulmod(rinv_b, inv_b, MB);
          str_len++;
        end
      end else if (rq.left > rq.right || rq.right >= str_len) begin
        r.status = dmph_pkg::STAT_RANGE;
      end else begin
        la = (rq.left != 0) ? pre_a[rq.left-1] : 0;
        lb = (rq.left != 0) ? pre_b[rq.left-1] : 0;
        r.hash_a = mulmod(30'((pre_a[rq.right] + MA - la) % MA), ipw_a[rq.left], MA);
        r.hash_b = mulmod(30'((pre_b[rq.right] + MB - lb) % MB), ipw_b[rq.left], MB);
        r.status = dmph_pkg::STAT_OK;
      end
      pending_hashes.insert(pending_hashes.size(), r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch on result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_result(dmph_pkg::out_req_t got);
      dmph_pkg::out_req_t want;
      results_seen++;
      if (pending_hashes.size() == 0) begin
        report_mismatch("unexpected result, nothing pending");
      end else begin
        want = pending_hashes.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", got.status, want.status));
        if (got.hash_a !== want.hash_a)
          report_mismatch($sformatf("hash_a got %0d expected %0d", got.hash_a, want.hash_a));
        if (got.hash_b !== want.hash_b)
          report_mismatch($sformatf("hash_b got %0d expected %0d", got.hash_b, want.hash_b));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  dmph_pkg::in_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  dmph_pkg::out_req_t out_req_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [29:0] cfg_data_i = '0;

  hash_scoreboard sb;
  int cycle_count = 0;
  // Percent chances of the sender idling and the receiver stalling in the current phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int appends_sent = 0;
  int queries_sent = 0;

  double_mod_prefix_string_hash_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_req_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // Cycle watchdog, so that a hung handshake ends the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[double_mod_prefix_string_hash_core] ERROR");
      $finish;
    end
  end

  // The receiver decides each cycle whether to stall; the stall applies to the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_req_o);
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Sends one request, idling first at the phase's rate, and waits until it is taken.
  // Valid stays high after the handshake so that a following request can go back to back;
  // stop_sending drops it whenever no request follows at once.
  task send_request(dmph_pkg::in_req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= rq;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(rq);
    if (rq.command == dmph_pkg::CMD_APPEND) appends_sent++;
    else queries_sent++;
  endtask

  task stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task send_append(bit fresh, logic [7:0] code);
    dmph_pkg::in_req_t rq;
    rq = '0;
    rq.command = dmph_pkg::CMD_APPEND;
    rq.new_string = fresh;
    rq.letter = code;
    rq.left = 12'($urandom);
    rq.right = 12'($urandom);
    send_request(rq);
  endtask

  task send_query(logic [11:0] lo, logic [11:0] hi);
    dmph_pkg::in_req_t rq;
    rq = '0;
    rq.command = dmph_pkg::CMD_QUERY;
    rq.new_string = 1'($urandom);
    rq.letter = 8'($urandom);
    rq.left = lo;
    rq.right = hi;
    send_request(rq);
  endtask

  // Waits until every expected result is back plus the core's settling time.
  task wait_drained();
    stop_sending();
    while (sb.pending_hashes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Register writes happen only with the core idle.
  task write_config(logic [1:0] idx, logic [29:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A random query: mostly valid ranges on the current string, some broken ones.
  task random_query();
    int unsigned len, lo, hi;
    len = sb.str_len;
    if (len != 0 && $urandom_range(9) < 8) begin
      hi = $urandom_range(len - 1);
      lo = $urandom_range(hi);
    end else begin
      lo = $urandom_range(4095);
      hi = $urandom_range(4095);
    end
    send_query(12'(lo), 12'(hi));
  endtask

  // A phase of random traffic: short strings with queries mixed in.
  task random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 6) send_append($urandom_range(19) == 0, 8'($urandom));
      else random_query();
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extreme letters, restart, queries at the edges and broken ranges.
    send_query(12'd0, 12'd0);
    send_append(1'b1, 8'd97);
    send_append(1'b0, 8'd0);
    send_append(1'b0, 8'd255);
    send_append(1'b0, 8'd96);
    send_append(1'b0, 8'd95);
    send_query(12'd0, 12'd4);
    send_query(12'd4, 12'd4);
    send_query(12'd2, 12'd3);
    send_query(12'd3, 12'd2);
    send_query(12'd0, 12'd5);
    send_query(12'd4095, 12'd4095);
    send_append(1'b1, 8'd122);
    send_query(12'd0, 12'd0);
    wait_drained();

    // Extreme register values, including values above the moduli.
    write_config(dmph_pkg::CFG_BASE_A, 30'd1);
    write_config(dmph_pkg::CFG_BASE_B, 30'h3FFFFFFF);
    write_config(dmph_pkg::CFG_INV_BASE_A, 30'h3FFFFFFF);
    write_config(dmph_pkg::CFG_INV_BASE_B, 30'd1);
    send_append(1'b1, 8'd200);
    send_append(1'b0, 8'd1);
    send_append(1'b0, 8'd128);
    send_query(12'd1, 12'd2);
    wait_drained();
    write_config(dmph_pkg::CFG_BASE_A, 30'd1000000006);
    write_config(dmph_pkg::CFG_BASE_B, 30'd1000000008);
    write_config(dmph_pkg::CFG_INV_BASE_A, 30'd1000000006);
    write_config(dmph_pkg::CFG_INV_BASE_B, 30'd1000000008);
    send_append(1'b1, 8'd98);
    send_append(1'b0, 8'd99);
    send_query(12'd1, 12'd1);
    wait_drained();
    write_config(dmph_pkg::CFG_BASE_A, dmph_pkg::BASE_A_RST);
    write_config(dmph_pkg::CFG_BASE_B, dmph_pkg::BASE_B_RST);
    write_config(dmph_pkg::CFG_INV_BASE_A, dmph_pkg::INV_BASE_A_RST);
    write_config(dmph_pkg::CFG_INV_BASE_B, dmph_pkg::INV_BASE_B_RST);

    // Random traffic in four idling phases.
    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(200);
    send_idle_pct = 76; recv_stall_pct = 0;  random_phase(150);
    send_idle_pct = 0;  recv_stall_pct = 76; random_phase(150);
    send_idle_pct = 14; recv_stall_pct = 14; random_phase(150);

    // Back pressure: the output holds off long enough for the core to stall its input.
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        random_phase(20);
        stop_sending();
      end
    join
    wait_drained();

    // Random register settings, then queries at the far edges of the position range.
    for (int k = 0; k < 4; k++) write_config(2'(k), 30'($urandom));
    random_phase(150);
    wait_drained();
    write_config(dmph_pkg::CFG_BASE_A, dmph_pkg::BASE_A_RST);
    send_append(1'b1, 8'($urandom));
    send_query(12'd0, 12'd4095);
    send_query(12'd4095, 12'd4095);
    send_query(12'd1000, 12'd3000);
    recv_stall_pct = 30;
    random_phase(40);
    wait_drained();

    $display("covered %0d appends and %0d queries, %0d results checked",
             appends_sent, queries_sent, sb.results_seen);
    $display("register extremes, restarts, bad ranges, four idling mixes and a long stall");
    if (sb.errors == 0 && sb.pending_hashes.size() == 0) begin
      $display("[double_mod_prefix_string_hash_core] OK");
    end else begin
      $display("[double_mod_prefix_string_hash_core] ERROR");
    end
    $finish;
  end
endmodule
